// ----- hw/rtl/adbq_pkg.sv -----
// Shared types, constants and arithmetic helpers for the angle derivative biquad filter.
// Used by adbq_cfg, adbq_core and the top level; depends on nothing.
package adbq_pkg;

  localparam int NUM_AXES       = 3;
  localparam int AXW            = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int COEF_FRAC_BITS = 14;
  localparam int ACC_W          = 52;
  localparam int PROD_W         = 50;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_B0 = 3'd0;
  localparam logic [2:0] REG_B1 = 3'd1;
  localparam logic [2:0] REG_A1 = 3'd2;
  localparam logic [2:0] REG_A2 = 3'd3;
  localparam logic [2:0] REG_SR = 3'd4;

  localparam logic signed [15:0] RST_B0 = 16'sd985;
  localparam logic signed [15:0] RST_B1 = 16'sd1971;
  localparam logic signed [15:0] RST_A1 = -16'sd16695;
  localparam logic signed [15:0] RST_A2 = 16'sd4253;
  localparam logic [9:0]         RST_SR = 10'd100;

  typedef struct packed {
    logic signed [15:0] b0;
    logic signed [15:0] b1;
    logic signed [15:0] a1;
    logic signed [15:0] a2;
    logic [9:0]         sample_rate;
  } coef_t;

  // One memory word: the whole history of one axis.
  typedef struct packed {
    logic signed [15:0] prev;
    logic signed [31:0] ru1;
    logic signed [31:0] ru2;
    logic signed [31:0] ry1;
    logic signed [31:0] ry2;
    logic signed [31:0] au1;
    logic signed [31:0] au2;
    logic signed [31:0] ay1;
    logic signed [31:0] ay2;
  } axis_state_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RUN,
    S_DONE
  } state_e;

  typedef enum logic [4:0] {
    OP_DIFF, OP_RB1, OP_RB0, OP_RA1, OP_RA2, OP_RU, OP_RSUM, OP_RATE,
    OP_ADIFF, OP_AB1, OP_AB0, OP_AA1, OP_AA2, OP_AU, OP_ASUM, OP_ACC, OP_WB
  } op_e;

  function automatic logic signed [31:0] sat32_f(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) r = v[31:0];
    else if (v[ACC_W-1])                       r = 32'sh8000_0000;
    else                                       r = 32'sh7fff_ffff;
    return r;
  endfunction

  // Round half up, drop the fraction bits of the taps, then saturate.
  function automatic logic signed [31:0] biq_f(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    t = acc + (ACC_W'(1) << (COEF_FRAC_BITS - 1));
    return sat32_f(t >>> COEF_FRAC_BITS);
  endfunction

endpackage

// ----- hw/rtl/adbq_if.sv -----
// Valid/ready channel interfaces for the input angles and the filtered results.
// No dependencies.
interface adbq_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  modport source(output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink(input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface adbq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] roll_rate;
  logic signed [31:0] pitch_rate;
  logic signed [31:0] yaw_rate;
  logic signed [31:0] roll_accel;
  logic signed [31:0] pitch_accel;
  logic signed [31:0] yaw_accel;
  modport source(output valid, roll_rate, pitch_rate, yaw_rate,
                 roll_accel, pitch_accel, yaw_accel, input ready);
  modport sink(input valid, roll_rate, pitch_rate, yaw_rate,
               roll_accel, pitch_accel, yaw_accel, output ready);
endinterface

// ----- hw/rtl/adbq_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module adbq_ram #(
  parameter int Width = 32,
  parameter int Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// ----- hw/rtl/adbq_cfg.sv -----
// APB-style register file holding the filter taps and the sample rate.
// Depends on adbq_pkg.
module adbq_cfg import adbq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output coef_t       coef_o
);
  coef_t      coef_q;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign coef_o = coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0          <= RST_B0;
      coef_q.b1          <= RST_B1;
      coef_q.a1          <= RST_A1;
      coef_q.a2          <= RST_A2;
      coef_q.sample_rate <= RST_SR;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_B0:  coef_q.b0          <= pwdata[15:0];
        REG_B1:  coef_q.b1          <= pwdata[15:0];
        REG_A1:  coef_q.a1          <= pwdata[15:0];
        REG_A2:  coef_q.a2          <= pwdata[15:0];
        REG_SR:  coef_q.sample_rate <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_B0:  prdata = {{16{coef_q.b0[15]}}, coef_q.b0};
      REG_B1:  prdata = {{16{coef_q.b1[15]}}, coef_q.b1};
      REG_A1:  prdata = {{16{coef_q.a1[15]}}, coef_q.a1};
      REG_A2:  prdata = {{16{coef_q.a2[15]}}, coef_q.a2};
      REG_SR:  prdata = {22'd0, coef_q.sample_rate};
      default: prdata = 32'd0;
    endcase
  end
endmodule

// ----- hw/rtl/adbq_core.sv -----
// Sequencer and shared multiply-accumulate datapath; per-axis history lives in one RAM.
// Depends on adbq_pkg, adbq_if and adbq_ram.
module adbq_core import adbq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  coef_t coef_i,
  adbq_in_if.sink    in_ch,
  adbq_out_if.source out_ch
);
  localparam int SW = $bits(axis_state_t);

  state_e state_q, state_d;
  op_e    op_q;
  logic [AXW-1:0] axis_q;
  logic [1:0]     phase_q;
  logic [NUM_AXES-1:0] vld_q;
  logic           rd_vld_q;

  logic signed [15:0] ang_q [NUM_AXES];
  logic signed [31:0] wr_rate_q [NUM_AXES];
  logic signed [31:0] wr_acc_q [NUM_AXES];
  logic signed [31:0] out_rate_q [NUM_AXES];
  logic signed [31:0] out_acc_q [NUM_AXES];
  logic out_vld_q;

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, prod_x;
  logic signed [31:0] raw_q, araw_q, rate_q, accel_q;

  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b, sr_s;
  logic signed [16:0] dif;
  logic [SW-1:0] rdata;
  axis_state_t ent, wb;
  logic re, we, in_acc, out_free, last_axis;

  adbq_ram #(.Width(SW), .Depth(NUM_AXES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(axis_q),
    .wdata_i(wb),
    .re_i   (re),
    .raddr_i(axis_q),
    .rdata_o(rdata)
  );

  // Entries never written since reset read as zero.
  assign ent       = rd_vld_q ? axis_state_t'(rdata) : '0;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_vld_q || out_ch.ready;
  assign last_axis = (axis_q == AXW'(NUM_AXES - 1));
  assign sr_s      = $signed({7'd0, coef_i.sample_rate});
  assign dif       = 17'(ang_q[axis_q]) - 17'(ent.prev);
  assign prod_d    = mul_a * mul_b;
  assign prod_x    = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op_q)
      OP_DIFF:  begin mul_a = 33'(dif);                  mul_b = sr_s;       end
      OP_RB1:   begin mul_a = 33'(ent.ru1);              mul_b = 17'(coef_i.b1); end
      OP_RB0:   begin mul_a = 33'(ent.ru2);              mul_b = 17'(coef_i.b0); end
      OP_RA1:   begin mul_a = -33'(ent.ry1);             mul_b = 17'(coef_i.a1); end
      OP_RA2:   begin mul_a = -33'(ent.ry2);             mul_b = 17'(coef_i.a2); end
      OP_RU:    begin mul_a = 33'(raw_q);                mul_b = 17'(coef_i.b0); end
      OP_ADIFF: begin mul_a = 33'(rate_q) - 33'(ent.ry1); mul_b = sr_s;      end
      OP_AB1:   begin mul_a = 33'(ent.au1);              mul_b = 17'(coef_i.b1); end
      OP_AB0:   begin mul_a = 33'(ent.au2);              mul_b = 17'(coef_i.b0); end
      OP_AA1:   begin mul_a = -33'(ent.ay1);             mul_b = 17'(coef_i.a1); end
      OP_AA2:   begin mul_a = -33'(ent.ay2);             mul_b = 17'(coef_i.a2); end
      OP_AU:    begin mul_a = 33'(araw_q);               mul_b = 17'(coef_i.b0); end
      default:  ;
    endcase
  end

  // Write-back word: the angle always, the rate history from the second item
  // on, the acceleration history from the third.
  always_comb begin
    wb      = ent;
    wb.prev = ang_q[axis_q];
    if (phase_q != 2'd0) begin
      wb.ru1 = raw_q;
      wb.ru2 = ent.ru1;
      wb.ry1 = rate_q;
      wb.ry2 = ent.ry1;
    end
    if (phase_q[1]) begin
      wb.au1 = araw_q;
      wb.au2 = ent.au1;
      wb.ay1 = accel_q;
      wb.ay2 = ent.ay1;
    end
  end

  always_comb begin
    state_d = state_q;
    re      = 1'b0;
    we      = 1'b0;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_READ;
      S_READ: begin
        re      = 1'b1;
        state_d = S_RUN;
      end
      S_RUN: if (op_q == OP_WB) begin
        we      = 1'b1;
        state_d = last_axis ? S_DONE : S_READ;
      end
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_DIFF;
      axis_q    <= '0;
      phase_q   <= 2'd0;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) axis_q <= '0;
      if (state_q == S_READ) begin
        rd_vld_q <= vld_q[axis_q];
        op_q     <= OP_DIFF;
      end
      if (state_q == S_RUN && op_q != OP_WB) op_q <= op_e'(op_q + 5'd1);
      if (we) begin
        vld_q[axis_q] <= 1'b1;
        if (!last_axis) axis_q <= axis_q + AXW'(1);
      end
      if (state_q == S_DONE && out_free) begin
        out_vld_q <= 1'b1;
        if (phase_q != 2'd2) phase_q <= phase_q + 2'd1;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ang_q[0] <= in_ch.roll_angle;
      if (NUM_AXES > 1) ang_q[1 % NUM_AXES] <= in_ch.pitch_angle;
      if (NUM_AXES > 2) ang_q[2 % NUM_AXES] <= in_ch.yaw_angle;
    end
    if (state_q == S_RUN) begin
      prod_q <= prod_d;
      case (op_q)
        OP_RB1:  raw_q  <= {prod_q[27:0], 4'd0};
        OP_AB1:  araw_q <= sat32_f(prod_x);
        OP_RB0, OP_AB0: acc_q <= prod_x;
        OP_RA1, OP_RA2, OP_RU, OP_RSUM,
        OP_AA1, OP_AA2, OP_AU, OP_ASUM: acc_q <= acc_q + prod_x;
        OP_RATE: rate_q  <= biq_f(acc_q);
        OP_ACC:  accel_q <= biq_f(acc_q);
        OP_WB: begin
          wr_rate_q[axis_q] <= wb.ry1;
          wr_acc_q[axis_q]  <= wb.ay1;
        end
        default: ;
      endcase
    end
    if (state_q == S_DONE && out_free) begin
      out_rate_q <= wr_rate_q;
      out_acc_q  <= wr_acc_q;
    end
  end

  assign out_ch.valid       = out_vld_q;
  assign out_ch.roll_rate   = out_rate_q[0];
  assign out_ch.pitch_rate  = out_rate_q[1 % NUM_AXES];
  assign out_ch.yaw_rate    = out_rate_q[2 % NUM_AXES];
  assign out_ch.roll_accel  = out_acc_q[0];
  assign out_ch.pitch_accel = out_acc_q[1 % NUM_AXES];
  assign out_ch.yaw_accel   = out_acc_q[2 % NUM_AXES];

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3) else $error("startup phase out of range");
  a_wr_only_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_RUN && op_q == OP_WB)) else $error("stray memory write");
  a_acc_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_READ && axis_q == '0)) else $error("item not started");
  a_phase_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free && phase_q == 2'd0) |=> phase_q == 2'd1)
    else $error("startup phase did not advance");
  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN |-> axis_q <= AXW'(NUM_AXES - 1)) else $error("axis out of range");
endmodule

// ----- hw/rtl/angle_derivative_biquad_filter.sv -----
// Top level of the angle derivative biquad filter: register port plus processing core.
// Depends on adbq_pkg, adbq_if, adbq_cfg and adbq_core.
//
// Usage: each item on in_ch_i carries roll, pitch and yaw angles (Q3.12). For every
// item one result leaves on out_ch_o with the smoothed rate and acceleration per axis
// (Q16.16, saturated). Both channels use valid/ready; an item moves when both are high.
// The taps and the sample rate sit on the APB-style port at byte addresses 0, 4, 8, 12
// and 16; write them only while the block is idle.
// Sequencing: one multiplier serves every tap of both filters on all axes.
// The axes are processed in turn, each with a memory read state and seventeen
// sequencer steps; the output register is loaded after the last axis. The input is
// ready again in the same cycle that the result becomes valid, so a new item is only
// accepted once the last one has finished.
// The finished result sits in an output register, so a new item is accepted while the
// receiver stalls; the block only waits if a second result is ready before the first
// has gone.
// Reset clears the startup phase and marks all history entries as zero. The first
// item only stores the angles, the second updates the rates, later ones update both.
module angle_derivative_biquad_filter import adbq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  adbq_in_if.sink     in_ch_i,
  adbq_out_if.source  out_ch_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  coef_t coef;

  adbq_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .coef_o (coef)
  );

  adbq_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .coef_i(coef),
    .in_ch (in_ch_i),
    .out_ch(out_ch_o)
  );
endmodule
